/* src/wheel_current_power_limiter_core_defines.svh */
// Assertion macros for the wheel current power limiter.
// Used by the top level; expects clk_i and rst_ni in the enclosing scope.
`ifndef WHEEL_CURRENT_POWER_LIMITER_CORE_DEFINES_SVH
`define WHEEL_CURRENT_POWER_LIMITER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WCPL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define WCPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/wcpl_pkg.sv */
// Shared widths, types and codes of the wheel current power limiter.
// Used by the channel interfaces and by every module of the block.
package wcpl_pkg;

  localparam int WHEEL_COUNT = 4;
  localparam int WC_SH       = $clog2(WHEEL_COUNT);

  localparam int CMD_W  = 16;
  localparam int MAG_W  = 16;
  localparam int TOT_W  = 18;
  localparam int E_W    = 12;
  localparam int WMC_W  = 15;
  localparam int OFL_W  = 17;
  localparam int SQ_W   = 2 * E_W;
  localparam int WQ_W   = WMC_W + SQ_W;
  localparam int NUM_W  = WQ_W + WC_SH;
  localparam int DT_W   = SQ_W + TOT_W;
  localparam int LO_W   = 24;
  localparam int HI_W   = NUM_W - LO_W;
  localparam int DVD_W  = MAG_W + NUM_W;

  // A scaled magnitude is strictly below the original one, so it fits in 15 bits.
  localparam int Q_W        = CMD_W - 1;
  localparam int PRE_STAGES = 4;
  localparam int PIPE_DEPTH = PRE_STAGES + Q_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHEEL_MAX   = 2'd0,
    CFG_LOW_THR     = 2'd1,
    CFG_OFFLINE_LIM = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_FULL,
    MODE_ENERGY,
    MODE_OFFLINE
  } lim_mode_e;

  typedef struct packed {
    logic [WMC_W-1:0] wheel_max;
    logic [E_W-1:0]   low_thr;
    logic [OFL_W-1:0] offline_lim;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    wheel_max:   15'd16384,
    low_thr:     12'd640,
    offline_lim: 17'd8000
  };

  typedef logic signed [CMD_W-1:0] cmd_t;

  typedef struct packed {
    logic [WHEEL_COUNT-1:0][CMD_W-1:0] cur;
    logic                              scaled;
  } res_t;

endpackage

/* src/wcpl_if.sv */
// Valid/ready channel interfaces of the wheel current power limiter:
// command items in, limited items out, and the register write channel.
// Depends on wcpl_pkg.
interface wcpl_in_if;
  import wcpl_pkg::*;
  logic            valid;
  logic            ready;
  logic            link_offline;
  logic [E_W-1:0]  buffer_energy;
  cmd_t            cmd_right_front;
  cmd_t            cmd_left_front;
  cmd_t            cmd_left_rear;
  cmd_t            cmd_right_rear;

  modport source (
    output valid, link_offline, buffer_energy,
    output cmd_right_front, cmd_left_front, cmd_left_rear, cmd_right_rear,
    input  ready
  );
  modport sink (
    input  valid, link_offline, buffer_energy,
    input  cmd_right_front, cmd_left_front, cmd_left_rear, cmd_right_rear,
    output ready
  );
endinterface

interface wcpl_out_if;
  import wcpl_pkg::*;
  logic valid;
  logic ready;
  cmd_t out_right_front;
  cmd_t out_left_front;
  cmd_t out_left_rear;
  cmd_t out_right_rear;
  logic was_scaled;

  modport source (
    output valid, out_right_front, out_left_front, out_left_rear, out_right_rear,
    output was_scaled,
    input  ready
  );
  modport sink (
    input  valid, out_right_front, out_left_front, out_left_rear, out_right_rear,
    input  was_scaled,
    output ready
  );
endinterface

interface wcpl_cfg_if;
  import wcpl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

/* src/wcpl_lane.sv */
// One wheel lane: magnitude, product with the limit numerator and a
// pipelined restoring divider, one quotient bit per stage. Depends on wcpl_pkg.
module wcpl_lane (
  input  logic                                          clk_i,
  input  logic                                          en_i,
  input  wcpl_pkg::cmd_t                                cmd_i,
  output logic [wcpl_pkg::MAG_W-1:0]                    mag_o,
  input  logic [wcpl_pkg::NUM_W-1:0]                    num_i,
  input  logic [wcpl_pkg::Q_W-1:0][wcpl_pkg::DT_W-1:0]  dvs_i,
  input  logic                                          scale_i,
  output wcpl_pkg::cmd_t                                res_o
);
  import wcpl_pkg::*;

  cmd_t                      cmd_q [PIPE_DEPTH];
  logic [MAG_W-1:0]          mag_q [2];
  logic [MAG_W+LO_W-1:0]     plo_q;
  logic [MAG_W+HI_W-1:0]     phi_q;
  logic [DVD_W-1:0]          rem_q [Q_W];
  logic [Q_W-1:0]            quot_q [Q_W];
  cmd_t                      cmd_last;
  logic [CMD_W-1:0]          q_ext;

  assign mag_o = cmd_i[CMD_W-1] ? MAG_W'(-cmd_i) : MAG_W'(cmd_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd_q[0] <= cmd_i;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        cmd_q[k] <= cmd_q[k-1];
      end
      mag_q[0] <= mag_o;
      mag_q[1] <= mag_q[0];
      // The numerator is cut in two so that each multiplier stays narrow.
      plo_q    <= (MAG_W+LO_W)'(mag_q[1]) * (MAG_W+LO_W)'(num_i[LO_W-1:0]);
      phi_q    <= (MAG_W+HI_W)'(mag_q[1]) * (MAG_W+HI_W)'(num_i[NUM_W-1:LO_W]);
      rem_q[0] <= (DVD_W'(phi_q) << LO_W) + DVD_W'(plo_q);
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    localparam int SH = Q_W - 1 - k;
    logic [DVD_W-1:0] dsh;
    logic             ge;
    logic [Q_W-1:0]   quot_prev;

    assign dsh = DVD_W'(dvs_i[k]) << SH;
    assign ge  = rem_q[k] >= dsh;

    if (k == 0) begin : g_first
      assign quot_prev = '0;
    end else begin : g_next
      assign quot_prev = quot_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quot_q[k] <= {quot_prev[Q_W-2:0], ge};
      end
    end

    if (k < Q_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? rem_q[k] - dsh : rem_q[k];
        end
      end
    end
  end

  assign cmd_last = cmd_q[PIPE_DEPTH-1];
  assign q_ext    = CMD_W'(quot_q[Q_W-1]);

  always_comb begin
    if (!scale_i) begin
      res_o = cmd_last;
    end else if (cmd_last[CMD_W-1]) begin
      res_o = -cmd_t'(q_ext);
    end else begin
      res_o = cmd_t'(q_ext);
    end
  end

endmodule

/* src/wcpl_limit.sv */
// Shared limit path: merges the lane magnitudes into a total, forms the
// limit as a fraction num/den, decides scaling and carries the divisor along
// the divider stages. Depends on wcpl_pkg.
module wcpl_limit (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          in_valid_i,
  input  logic                                          link_offline_i,
  input  logic [wcpl_pkg::E_W-1:0]                      buffer_energy_i,
  input  logic [wcpl_pkg::MAG_W-1:0]                    mag_i [wcpl_pkg::WHEEL_COUNT],
  input  wcpl_pkg::cfg_t                                cfg_i,
  output logic [wcpl_pkg::NUM_W-1:0]                    num_o,
  output logic [wcpl_pkg::Q_W-1:0][wcpl_pkg::DT_W-1:0]  dvs_o,
  output logic                                          scale_o,
  output logic                                          res_valid_o
);
  import wcpl_pkg::*;

  logic [TOT_W-1:0]      total_d, total_q;
  lim_mode_e             mode_d, mode_q;
  logic [SQ_W-1:0]       thr_sq, esq_d, esq_q, den_d, den_q;
  logic [WQ_W-1:0]       wq_prod;
  logic [NUM_W-1:0]      num_d, num_q;
  logic [DT_W-1:0]       dt_d, dt_q, dt3_q;
  logic                  scale_q;
  logic [Q_W-1:0][DT_W-1:0] dvs_q;
  logic [Q_W:0]          sc_q;
  logic [PIPE_DEPTH-1:0] vld_q;

  always_comb begin
    total_d = '0;
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      total_d = total_d + TOT_W'(mag_i[i]);
    end
  end

  always_comb begin
    if (link_offline_i) begin
      mode_d = MODE_OFFLINE;
    end else if (buffer_energy_i < cfg_i.low_thr) begin
      mode_d = MODE_ENERGY;
    end else begin
      mode_d = MODE_FULL;
    end
  end

  assign thr_sq = SQ_W'(cfg_i.low_thr) * SQ_W'(cfg_i.low_thr);
  assign esq_d  = SQ_W'(buffer_energy_i) * SQ_W'(buffer_energy_i);
  assign den_d  = (mode_d == MODE_ENERGY) ? thr_sq : SQ_W'(1);

  assign wq_prod = WQ_W'(cfg_i.wheel_max) * WQ_W'(esq_q);

  always_comb begin
    case (mode_q)
      MODE_OFFLINE: num_d = NUM_W'(cfg_i.offline_lim);
      MODE_ENERGY:  num_d = NUM_W'(wq_prod) << WC_SH;
      default:      num_d = NUM_W'(cfg_i.wheel_max) << WC_SH;
    endcase
  end

  assign dt_d = DT_W'(den_q) * DT_W'(total_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      total_q <= total_d;
      mode_q  <= mode_d;
      esq_q   <= esq_d;
      den_q   <= den_d;
      num_q   <= num_d;
      dt_q    <= dt_d;
      scale_q <= dt_q > DT_W'(num_q);
      dt3_q   <= dt_q;
      dvs_q   <= {dvs_q[Q_W-2:0], dt3_q};
      sc_q    <= {sc_q[Q_W-1:0], scale_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  assign num_o       = num_q;
  assign dvs_o       = dvs_q;
  assign scale_o     = sc_q[Q_W];
  assign res_valid_o = vld_q[PIPE_DEPTH-1];

endmodule

/* src/wcpl_skid.sv */
// Output register with a one-entry skid buffer behind it, so the pipeline
// keeps a registered ready while the receiver stalls. Depends on wcpl_pkg.
module wcpl_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  wcpl_pkg::res_t data_i,
  output logic           ready_o,
  output logic           valid_o,
  output wcpl_pkg::res_t data_o,
  input  logic           ready_i
);
  import wcpl_pkg::*;

  logic out_valid_q, skid_valid_q;
  res_t out_data_q, skid_data_q;
  logic take;
  logic load_out;

  assign ready_o  = !skid_valid_q;
  assign take     = valid_i && ready_o;
  assign load_out = !out_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q  <= skid_valid_q || take;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= skid_valid_q ? skid_data_q : data_i;
    end else if (take) begin
      skid_data_q <= data_i;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

endmodule

/* src/wheel_current_power_limiter_core.sv */
// Wheel current power limiter, top level. Depends on wcpl_pkg, the channel
// interfaces, wcpl_lane, wcpl_limit, wcpl_skid and the assertion header.
//
// An item on in_i carries four signed wheel current commands, the referee
// link offline flag and the remaining buffer energy in 1/16 J. For every
// item the block sends one item on out_o with the four limited currents and
// was_scaled, in order. Both channels complete an item when valid and ready
// are high at a rising clock edge. Registers are written through cfg_i,
// which is always ready; they are meant to change only while no item is in
// flight.
// Four lanes, one per wheel, run side by side; the limit path merges their
// magnitudes into the total. The block takes one item per cycle while the
// skid entry is free. The first stage loads at the accepting edge; three
// more stages of limit and product arithmetic, a fifteen-stage divider and
// the output register follow it.
// When the receiver stalls, the output register holds its item and one more
// result lands in the skid entry; only then does in_i drop ready. Reset
// empties the pipeline and restores the register defaults.
`include "wheel_current_power_limiter_core_defines.svh"

module wheel_current_power_limiter_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  wcpl_in_if.sink  in_i,
  wcpl_cfg_if.sink cfg_i,
  wcpl_out_if.source out_o
);
  import wcpl_pkg::*;

  // Register bank. Writes to an unused index are taken and ignored.
  cfg_t cfg_d, cfg_q;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.idx))
        CFG_WHEEL_MAX:   cfg_d.wheel_max   = cfg_i.data[WMC_W-1:0];
        CFG_LOW_THR:     cfg_d.low_thr     = cfg_i.data[E_W-1:0];
        CFG_OFFLINE_LIM: cfg_d.offline_lim = cfg_i.data[OFL_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The whole pipeline advances together whenever the skid entry is free.
  logic en;
  logic in_take;

  assign in_i.ready = en;
  assign in_take    = in_i.valid && en;

  // Lane order follows the command fields: right front, left front,
  // left rear, right rear.
  cmd_t             cmd      [WHEEL_COUNT];
  cmd_t             lane_res [WHEEL_COUNT];
  logic [MAG_W-1:0] mag      [WHEEL_COUNT];

  assign cmd[0] = in_i.cmd_right_front;
  assign cmd[1] = in_i.cmd_left_front;
  assign cmd[2] = in_i.cmd_left_rear;
  assign cmd[3] = in_i.cmd_right_rear;

  logic [NUM_W-1:0]         num;
  logic [Q_W-1:0][DT_W-1:0] dvs;
  logic                     scale;
  logic                     res_valid;

  wcpl_limit u_limit (
    .clk_i,
    .rst_ni,
    .en_i            (en),
    .in_valid_i      (in_take),
    .link_offline_i  (in_i.link_offline),
    .buffer_energy_i (in_i.buffer_energy),
    .mag_i           (mag),
    .cfg_i           (cfg_q),
    .num_o           (num),
    .dvs_o           (dvs),
    .scale_o         (scale),
    .res_valid_o     (res_valid)
  );

  for (genvar w = 0; w < WHEEL_COUNT; w++) begin : g_lane
    wcpl_lane u_lane (
      .clk_i,
      .en_i    (en),
      .cmd_i   (cmd[w]),
      .mag_o   (mag[w]),
      .num_i   (num),
      .dvs_i   (dvs),
      .scale_i (scale),
      .res_o   (lane_res[w])
    );
  end

  // Merge the lane results and the shared scaling decision into one item.
  res_t res;

  always_comb begin
    res.scaled = scale;
    for (int w = 0; w < WHEEL_COUNT; w++) begin
      res.cur[w] = lane_res[w];
    end
  end

  res_t out_data;
  logic out_valid;

  wcpl_skid u_skid (
    .clk_i,
    .rst_ni,
    .valid_i (res_valid),
    .data_i  (res),
    .ready_o (en),
    .valid_o (out_valid),
    .data_o  (out_data),
    .ready_i (out_o.ready)
  );

  assign out_o.valid           = out_valid;
  assign out_o.out_right_front = out_data.cur[0];
  assign out_o.out_left_front  = out_data.cur[1];
  assign out_o.out_left_rear   = out_data.cur[2];
  assign out_o.out_right_rear  = out_data.cur[3];
  assign out_o.was_scaled      = out_data.scaled;

  // The input only stalls while a finished result waits at the output.
  `WCPL_ASSERT_NOW(a_stall_has_result, !in_i.ready, out_o.valid, "input stalled with no result waiting")
  // The skid entry fills only behind a stalled output item.
  `WCPL_ASSERT_NOW(a_fill_on_stall, $fell(in_i.ready), $past(out_o.valid && !out_o.ready), "skid filled without an output stall")
  // The skid entry drains only when the output item is taken.
  `WCPL_ASSERT_NOW(a_drain_on_take, $rose(in_i.ready), $past(out_o.valid && out_o.ready), "skid drained without an output transfer")
  // A full skid entry stays full while the receiver keeps stalling.
  `WCPL_ASSERT_NEXT(a_hold_full, !in_i.ready && !out_o.ready, !in_i.ready, "skid entry lost during a stall")

endmodule

/* bench/wheel_current_power_limiter_core_test.sv */
// Self-checking bench for the wheel current power limiter core: directed and
// random command items against a built-in predictor of the limited currents.
// Depends on wcpl_pkg, the wcpl channel interfaces and the core itself.
`timescale 1ns / 100ps

module wheel_current_power_limiter_core_test;
  import wcpl_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  // One command item as it crosses in_i. Wheel order is right front, left
  // front, left rear, right rear, the same order res_t uses for its currents.
  typedef struct packed {
    logic                              offline;
    logic [E_W-1:0]                    energy;
    logic [WHEEL_COUNT-1:0][CMD_W-1:0] cmd;
  } wheel_cmd_t;

  logic clk_i;
  logic rst_ni;

  wcpl_in_if  in_if ();
  wcpl_cfg_if cfg_if ();
  wcpl_out_if out_if ();

  wheel_current_power_limiter_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // Register values the predictor works with; they follow every write made
  // on cfg_i and start from the reset defaults.
  cfg_t limits = CFG_RESET;

  // Predicted result items, oldest first, one per accepted command item.
  res_t limited_expected[$];

  int  failures    = 0;
  int  cycle_count = 0;
  bit  src_calm    = 1'b0;
  bit  sink_calm   = 1'b0;

  initial begin
    clk_i = 1'b0;
  end

  always #6 clk_i = ~clk_i;

  // Watchdog: a stuck handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[wheel_current_power_limiter_core] ERROR");
      $finish;
    end
  end

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // Gap length for either side of the block: mostly none or short, now and
  // then a long one. In a calm stretch there are no gaps at all.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(11, 40);
  endfunction

  // Predicts the limited currents for one command item under the current
  // register values. The total limit stays an exact fraction num/den, so the
  // scaled current is the one truncation of |c| * num / (den * total).
  function automatic res_t limit_currents(input wheel_cmd_t c);
    res_t              res;
    cmd_t              s;
    longint            v;
    longint            r;
    longint unsigned   mag [WHEEL_COUNT];
    longint unsigned   total;
    longint unsigned   num;
    longint unsigned   den;
    longint unsigned   e;
    longint unsigned   q;
    lim_mode_e         mode;
    logic              scale;

    total = 0;
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      s      = c.cmd[i];
      v      = s;
      mag[i] = (v < 0) ? longint'(-v) : longint'(v);
      total += mag[i];
    end

    e = c.energy;
    if (c.offline) begin
      mode = MODE_OFFLINE;
    end else if (c.energy < limits.low_thr) begin
      mode = MODE_ENERGY;
    end else begin
      mode = MODE_FULL;
    end

    case (mode)
      MODE_OFFLINE: begin
        num = limits.offline_lim;
        den = 1;
      end
      MODE_ENERGY: begin
        // Quadratic fade: full limit times (energy / threshold)^2.
        num = longint'(WHEEL_COUNT) * limits.wheel_max * e * e;
        den = longint'(limits.low_thr) * limits.low_thr;
      end
      default: begin
        num = longint'(WHEEL_COUNT) * limits.wheel_max;
        den = 1;
      end
    endcase

    // An all-zero item never scales, even against a zero limit.
    scale = (total * den) > num;

    for (int i = 0; i < WHEEL_COUNT; i++) begin
      s = c.cmd[i];
      if (scale) begin
        q = (mag[i] * num) / (den * total);
        r = (s < 0) ? -longint'(q) : longint'(q);
        res.cur[i] = r[CMD_W-1:0];
      end else begin
        res.cur[i] = c.cmd[i];
      end
    end
    res.scaled = scale;
    return res;
  endfunction

  // Offers one command item after a random gap and records its prediction
  // once in_i has taken it. Valid stays high on return, so items can follow
  // back to back without a drop.
  task automatic push_command(input wheel_cmd_t it);
    int gap;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.link_offline    <= it.offline;
    in_if.buffer_energy   <= it.energy;
    in_if.cmd_right_front <= it.cmd[0];
    in_if.cmd_left_front  <= it.cmd[1];
    in_if.cmd_left_rear   <= it.cmd[2];
    in_if.cmd_right_rear  <= it.cmd[3];
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    limited_expected.push_back(limit_currents(it));
  endtask

  // Stops sending and waits until every predicted result has come back.
  // Every item yields a result, so the pipeline is empty afterwards.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (limited_expected.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Writes all three registers back to back while the block is idle, then
  // lets the predictor use the new values.
  task automatic write_limits(input cfg_t c);
    cfg_idx_e              regs [3];
    logic [CFG_DATA_W-1:0] vals [3];
    regs[0] = CFG_WHEEL_MAX;
    regs[1] = CFG_LOW_THR;
    regs[2] = CFG_OFFLINE_LIM;
    vals[0] = CFG_DATA_W'(c.wheel_max);
    vals[1] = CFG_DATA_W'(c.low_thr);
    vals[2] = CFG_DATA_W'(c.offline_lim);
    drain_results();
    for (int k = 0; k < 3; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.idx   <= regs[k];
      cfg_if.data  <= vals[k];
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
    end
    cfg_if.valid <= 1'b0;
    limits = c;
    @(posedge clk_i);
  endtask

  function automatic wheel_cmd_t make_cmd(input bit offline, input int energy,
                                          input int rf, input int lf,
                                          input int lr, input int rr);
    wheel_cmd_t c;
    c.offline = offline;
    c.energy  = E_W'(energy);
    c.cmd[0]  = CMD_W'(rf);
    c.cmd[1]  = CMD_W'(lf);
    c.cmd[2]  = CMD_W'(lr);
    c.cmd[3]  = CMD_W'(rr);
    return c;
  endfunction

  // Random command item, shaped so that the three limit modes and both sides
  // of the scaling decision all come up often.
  function automatic wheel_cmd_t make_random_cmd();
    wheel_cmd_t c;
    int         r;
    int         bound;
    int         v;

    c.offline = ($urandom_range(0, 99) < 20);
    r = $urandom_range(0, 99);
    if (r < 35) begin
      c.energy = E_W'($urandom_range(0, limits.low_thr - 1));
    end else if (r < 65) begin
      c.energy = E_W'($urandom_range(limits.low_thr, (1 << E_W) - 1));
    end else if (r < 75) begin
      c.energy = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      c.energy = E_W'($urandom());
    end

    // Per-wheel scale near the active limit, so the total sits around it.
    bound = c.offline ? int'(limits.offline_lim) / WHEEL_COUNT : int'(limits.wheel_max);
    bound = bound + bound / 8 + 1;

    for (int i = 0; i < WHEEL_COUNT; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        c.cmd[i] = CMD_W'($urandom());
      end else if (r < 70) begin
        v = $urandom_range(0, bound);
        c.cmd[i] = $urandom_range(0, 1) ? CMD_W'(-v) : CMD_W'(v);
      end else if (r < 85) begin
        c.cmd[i] = CMD_W'($urandom_range(0, 255)) - CMD_W'(128);
      end else begin
        case ($urandom_range(0, 3))
          0:       c.cmd[i] = CMD_W'(-32768);
          1:       c.cmd[i] = CMD_W'(32767);
          2:       c.cmd[i] = '0;
          default: c.cmd[i] = '1;
        endcase
      end
    end
    return c;
  endfunction

  // Compares each result item taken from out_o with the oldest prediction.
  always @(posedge clk_i) begin
    res_t       got;
    res_t       want;
    string      wheel_names [WHEEL_COUNT];
    wheel_names = '{"right_front", "left_front", "left_rear", "right_rear"};
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.cur[0] = out_if.out_right_front;
      got.cur[1] = out_if.out_left_front;
      got.cur[2] = out_if.out_left_rear;
      got.cur[3] = out_if.out_right_rear;
      got.scaled = out_if.was_scaled;
      if (limited_expected.size() == 0) begin
        note_failure($sformatf("unexpected result item: %0d %0d %0d %0d scaled %0b",
                               $signed(got.cur[0]), $signed(got.cur[1]),
                               $signed(got.cur[2]), $signed(got.cur[3]), got.scaled));
      end else begin
        want = limited_expected.pop_front();
        for (int i = 0; i < WHEEL_COUNT; i++) begin
          if (got.cur[i] !== want.cur[i]) begin
            note_failure($sformatf("mismatch on %s: expected %0d, got %0d",
                                   wheel_names[i], $signed(want.cur[i]),
                                   $signed(got.cur[i])));
          end
        end
        if (got.scaled !== want.scaled) begin
          note_failure($sformatf("mismatch on was_scaled: expected %0b, got %0b",
                                 want.scaled, got.scaled));
        end
      end
    end
  end

  // Receiver: ready runs of random length broken by stalls of random length.
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = pick_gap(sink_calm);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Register defaults: the three limit modes, the mode boundaries, the
  // offline limit reached exactly, all-zero items and the most negative
  // command.
  task automatic test_reset_defaults();
    push_command(make_cmd(0, 4095, 0, 0, 0, 0));
    push_command(make_cmd(0, 4095, 32767, 32767, 32767, 32767));
    push_command(make_cmd(0, 4095, -32768, -32768, -32768, -32768));
    push_command(make_cmd(1, 0, -32768, 32767, 0, 1));
    push_command(make_cmd(0, 0, 5, -7, 1, -1));
    push_command(make_cmd(0, 0, 0, 0, 0, 0));
    push_command(make_cmd(0, 639, 30000, -30000, 20000, -10000));
    push_command(make_cmd(0, 640, 30000, -30000, 20000, -10000));
    push_command(make_cmd(0, 320, 12000, 4000, -4000, -1));
    // Total equal to the offline limit passes; one more unit scales.
    push_command(make_cmd(1, 4095, 2000, -2000, 2000, -2000));
    push_command(make_cmd(1, 4095, 2001, -2000, 2000, -2000));
    push_command(make_cmd(1, 2730, -21846, 10922, -1366, 5461));
  endtask

  // Zero limit in every mode: nonzero commands drop to zero, an all-zero
  // item is left alone. The threshold sits at its lowest nonzero value.
  task automatic test_zero_limit();
    cfg_t c;
    c.wheel_max   = '0;
    c.low_thr     = 12'd1;
    c.offline_lim = '0;
    write_limits(c);
    push_command(make_cmd(0, 4095, 32767, -32768, 1, -1));
    push_command(make_cmd(0, 0, 100, -200, 300, -400));
    push_command(make_cmd(1, 1, -32768, -32768, 32767, 32767));
    push_command(make_cmd(0, 0, 0, 0, 0, 0));
    push_command(make_cmd(1, 4095, 0, 0, 0, 0));
  endtask

  // Largest register values: the offline limit equal to the largest total
  // of positive commands, the threshold at its top, energy just under and at it.
  task automatic test_max_limits();
    cfg_t c;
    c.wheel_max   = 15'd32767;
    c.low_thr     = 12'd4095;
    c.offline_lim = 17'd131068;
    write_limits(c);
    push_command(make_cmd(1, 0, -32768, -32768, -32768, -32768));
    push_command(make_cmd(1, 0, 32767, 32767, 32767, 32767));
    push_command(make_cmd(0, 4094, -32768, -32768, -32768, -32768));
    push_command(make_cmd(0, 4095, -32768, 32767, -32768, 32767));
    push_command(make_cmd(0, 1, 32767, -1, 1, -32768));
    push_command(make_cmd(0, 2048, 21845, -10923, 3, 0));
  endtask

  // One random register setting, leaning to the range ends, then a run of
  // random items. Part of the run has no gaps on either side, and halfway
  // through the sender waits until every pending result has come.
  task automatic test_random_phase(input int n_items);
    cfg_t c;
    int   r;
    r = $urandom_range(0, 9);
    c.wheel_max = (r < 2) ? '0 : (r < 4) ? 15'd32767 : WMC_W'($urandom());
    r = $urandom_range(0, 9);
    c.low_thr = (r < 2) ? 12'd1 : (r < 4) ? 12'd4095 : E_W'($urandom_range(1, 4095));
    r = $urandom_range(0, 9);
    c.offline_lim = (r < 2) ? '0 : (r < 4) ? 17'd131068 : OFL_W'($urandom_range(0, 131068));
    write_limits(c);
    for (int k = 0; k < n_items; k++) begin
      src_calm  = (k >= n_items / 4) && (k < n_items / 4 + 20);
      sink_calm = src_calm;
      if (k == n_items / 2) begin
        drain_results();
      end
      push_command(make_random_cmd());
    end
    src_calm  = 1'b0;
    sink_calm = 1'b0;
  endtask

  initial begin
    rst_ni                <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.link_offline    <= 1'b0;
    in_if.buffer_energy   <= '0;
    in_if.cmd_right_front <= '0;
    in_if.cmd_left_front  <= '0;
    in_if.cmd_left_rear   <= '0;
    in_if.cmd_right_rear  <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.idx            <= CFG_WHEEL_MAX;
    cfg_if.data           <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_zero_limit();
    test_max_limits();
    for (int p = 0; p < 5; p++) begin
      test_random_phase(106);
    end

    // Let any stray result show up after the last expected one.
    drain_results();
    repeat (PIPE_DEPTH + 8) @(posedge clk_i);
    if (failures == 0) begin
      $display("[wheel_current_power_limiter_core] OK");
    end else begin
      $display("[wheel_current_power_limiter_core] ERROR");
    end
    $finish;
  end

endmodule
